// ===== rtl/vtx_pkg.sv =====
// Shared types and code constants for the Videotex to UTF-8 transcoder.
// No dependencies; imported by the decoder and the top level.
`timescale 1ns / 1ps
`default_nettype none

package vtx_pkg;

   // Videotex control codes
   localparam logic [7:0] CODE_SO    = 8'h0E;
   localparam logic [7:0] CODE_SI    = 8'h0F;
   localparam logic [7:0] CODE_SS2   = 8'h19;
   localparam logic [7:0] CODE_ESC10 = 8'h10;
   localparam logic [7:0] CODE_ESC12 = 8'h12;
   localparam logic [7:0] CODE_ESC13 = 8'h13;
   localparam logic [7:0] CODE_ESC   = 8'h1B;
   localparam logic [7:0] CODE_ESC1F = 8'h1F;

   // Accent selectors following SS2
   localparam logic [7:0] ACC_GRAVE  = 8'h41;
   localparam logic [7:0] ACC_ACUTE  = 8'h42;
   localparam logic [7:0] ACC_CIRC   = 8'h43;
   localparam logic [7:0] ACC_UMLAUT = 8'h48;
   localparam logic [7:0] ACC_CEDIL  = 8'h4B;
   localparam logic [3:0] ACC_NIBBLE = 4'h4;

   // UTF-8 fragments
   localparam logic [7:0] UTF_LEAD_C2   = 8'hC2;
   localparam logic [7:0] UTF_LEAD_C3   = 8'hC3;
   localparam logic [7:0] UTF_LEAD_C5   = 8'hC5;
   localparam logic [7:0] UTF_LEAD_CE   = 8'hCE;
   localparam logic [7:0] UTF_LEAD_E2   = 8'hE2;
   localparam logic [7:0] UTF_LEAD_EF   = 8'hEF;
   localparam logic [7:0] UTF_LEAD_F0   = 8'hF0;
   localparam logic [7:0] UTF_SEXT_1    = 8'h9F;
   localparam logic [7:0] UTF_SEXT_2    = 8'hAC;
   localparam logic [7:0] UTF_BLOCK_1   = 8'h96;
   localparam logic [7:0] UTF_UNKNOWN   = 8'h5F;

   localparam int unsigned OUT_BYTES = 4;

   // Byte history and mode carried between items
   typedef struct packed {
      logic       graphics_mode;
      logic [7:0] last_byte;
      logic [7:0] before_last_byte;
   } hist_type;

   // One decoded result
   typedef struct packed {
      logic [2:0]                     out_count;
      logic [OUT_BYTES-1:0][7:0]      out_bytes;
      logic                           error;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/vtx_decode.sv =====
// Combinational decode of one Videotex byte into up to four UTF-8 bytes.
// Depends on vtx_pkg; computes the result and the next byte history.
`timescale 1ns / 1ps
`default_nettype none

module vtx_decode
   import vtx_pkg::*;
(
   input  wire logic [7:0] vt_byte,
   input  wire logic       start_of_message,
   input  wire logic       start_graphics,
   input  wire hist_type   hist,
   output result_type      result,
   output hist_type        hist_next
);

   // Low byte of the accented Latin-1 letter, zero when there is no match
   function automatic logic [7:0] accent_low(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] lo;
      lo = 8'h00;
      case (acc)
         ACC_GRAVE: begin
            if (b == 8'h61) lo = 8'hA0;
            else if (b == 8'h65) lo = 8'hA8;
            else if (b == 8'h75) lo = 8'hB9;
         end
         ACC_ACUTE: begin
            if (b == 8'h65) lo = 8'hA9;
         end
         ACC_CIRC: begin
            if (b == 8'h61) lo = 8'hA2;
            else if (b == 8'h65) lo = 8'hAA;
            else if (b == 8'h69) lo = 8'hAE;
            else if (b == 8'h6F) lo = 8'hB4;
            else if (b == 8'h75) lo = 8'hBB;
         end
         ACC_UMLAUT: begin
            if (b == 8'h61) lo = 8'hA4;
            else if (b == 8'h65) lo = 8'hAB;
            else if (b == 8'h69) lo = 8'hAF;
            else if (b == 8'h6F) lo = 8'hB6;
            else if (b == 8'h75) lo = 8'hBC;
         end
         ACC_CEDIL: begin
            if (b == 8'h63) lo = 8'hA7;
         end
         default: lo = 8'h00;
      endcase
      return lo;
   endfunction

   hist_type   eff;
   logic [7:0] lo;
   logic [7:0] sext_off;
   logic       sext_hit;

   always_comb begin
      // message start reloads the mode and drops the history
      eff = hist;
      if (start_of_message) begin
         eff.graphics_mode    = start_graphics;
         eff.last_byte        = 8'h00;
         eff.before_last_byte = 8'h00;
      end

      result    = '0;
      hist_next = eff;
      lo        = accent_low(eff.last_byte, vt_byte);

      // sextant ranges: offset into U+1FB00 block skipping the plain blocks
      sext_hit = 1'b1;
      if (vt_byte >= 8'h21 && vt_byte <= 8'h34)      sext_off = 8'h5F;
      else if (vt_byte >= 8'h36 && vt_byte <= 8'h49) sext_off = 8'h5E;
      else if (vt_byte >= 8'h4B && vt_byte <= 8'h5E) sext_off = 8'h5D;
      else if (vt_byte >= 8'h60 && vt_byte <= 8'h69) sext_off = 8'h3E;
      else if (vt_byte >= 8'h6B && vt_byte <= 8'h6E) sext_off = 8'h3D;
      else begin
         sext_off = 8'h00;
         sext_hit = 1'b0;
      end

      if (vt_byte < 8'h20) begin
         // control bytes, either mode
         case (vt_byte)
            CODE_SO:  hist_next.graphics_mode = 1'b1;
            CODE_SI:  hist_next.graphics_mode = 1'b0;
            CODE_SS2: ;
            CODE_ESC10, CODE_ESC12, CODE_ESC13, CODE_ESC, CODE_ESC1F:
               result.error = 1'b1;
            default: begin
               result.out_count    = 3'd1;
               result.out_bytes[0] = vt_byte;
            end
         endcase
      end else if (eff.graphics_mode) begin
         // mosaic set
         if (vt_byte == 8'h20 || vt_byte == 8'h7F) begin
            result.out_count    = 3'd1;
            result.out_bytes[0] = vt_byte;
         end else if (vt_byte == 8'h35) begin
            result.out_count = 3'd3;
            result.out_bytes[0] = UTF_LEAD_E2;
            result.out_bytes[1] = UTF_BLOCK_1;
            result.out_bytes[2] = 8'h8C;
         end else if (vt_byte == 8'h4A || vt_byte == 8'h6A) begin
            result.out_count = 3'd3;
            result.out_bytes[0] = UTF_LEAD_E2;
            result.out_bytes[1] = UTF_BLOCK_1;
            result.out_bytes[2] = 8'h90;
         end else if (vt_byte == 8'h5F) begin
            result.out_count = 3'd3;
            result.out_bytes[0] = UTF_LEAD_E2;
            result.out_bytes[1] = UTF_BLOCK_1;
            result.out_bytes[2] = 8'h88;
         end else if (sext_hit) begin
            result.out_count = 3'd4;
            result.out_bytes[0] = UTF_LEAD_F0;
            result.out_bytes[1] = UTF_SEXT_1;
            result.out_bytes[2] = UTF_SEXT_2;
            result.out_bytes[3] = vt_byte + sext_off;
         end
      end else if (eff.last_byte == CODE_SS2) begin
         // symbol after SS2; an accent selector waits for its letter
         if (vt_byte[7:4] != ACC_NIBBLE) begin
            result.out_count    = 3'd1;
            result.out_bytes[0] = UTF_UNKNOWN;
            case (vt_byte)
               8'h23: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C2;
                  result.out_bytes[1] = 8'hA3;
               end
               8'h24: result.out_bytes[0] = 8'h24;
               8'h26: begin
                  result.out_count = 3'd3;
                  result.out_bytes[0] = UTF_LEAD_EF;
                  result.out_bytes[1] = 8'hBC;
                  result.out_bytes[2] = 8'h83;
               end
               8'h27: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C2;
                  result.out_bytes[1] = 8'hA7;
               end
               8'h2C, 8'h2D, 8'h2E, 8'h2F: begin
                  result.out_count = 3'd3;
                  result.out_bytes[0] = UTF_LEAD_E2;
                  result.out_bytes[1] = 8'h86;
                  result.out_bytes[2] = {6'b100100, vt_byte[1:0]};
               end
               8'h30: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C2;
                  result.out_bytes[1] = 8'hB0;
               end
               8'h31: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C2;
                  result.out_bytes[1] = 8'hB1;
               end
               8'h35: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C3;
                  result.out_bytes[1] = 8'hB7;
               end
               8'h3C, 8'h3D, 8'h3E: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C2;
                  result.out_bytes[1] = vt_byte + 8'h80;
               end
               8'h6A: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C5;
                  result.out_bytes[1] = 8'h92;
               end
               8'h7A: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_C5;
                  result.out_bytes[1] = 8'h93;
               end
               8'h7B: begin
                  result.out_count = 3'd2;
                  result.out_bytes[0] = UTF_LEAD_CE;
                  result.out_bytes[1] = 8'hB2;
               end
               default: result.out_bytes[0] = UTF_UNKNOWN;
            endcase
         end
      end else if (eff.before_last_byte == CODE_SS2 && eff.last_byte[7:4] == ACC_NIBBLE) begin
         // accented letter, or the plain letter when unmatched
         if (lo != 8'h00) begin
            result.out_count    = 3'd2;
            result.out_bytes[0] = UTF_LEAD_C3;
            result.out_bytes[1] = lo;
         end else begin
            result.out_count    = 3'd1;
            result.out_bytes[0] = vt_byte;
         end
      end else begin
         result.out_count    = 3'd1;
         result.out_bytes[0] = vt_byte;
      end

      // every byte enters the history
      hist_next.before_last_byte = eff.last_byte;
      hist_next.last_byte        = vt_byte;
   end

endmodule

`default_nettype wire

// ===== rtl/videotex_to_utf8_transcoder.sv =====
// Top level of the Videotex to UTF-8 transcoder: input register, decode, result register.
// Depends on vtx_pkg and vtx_decode.
`timescale 1ns / 1ps
`default_nettype none

// One Videotex byte per transfer in, one result per transfer out: a count of 0 to 4
// UTF-8 bytes, the bytes (zero past the count) and an error flag for unsupported
// escape codes, after which the message should be dropped. The block sustains one
// byte per cycle while rsp_ready stays high. An input transfer fills the input
// register, and the decoded result then loads the result register, which drives
// the rsp ports. A stalled result holds the input register, and req_ready drops
// while both registers are full and the result is stalled.
// req_start_of_message loads the mode from the start_graphics register and clears
// the byte history before that byte is decoded. Write the register only while idle.
module videotex_to_utf8_transcoder
   import vtx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_vt_byte,
   input  wire logic       req_start_of_message,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_out_count,
   output logic [7:0]      rsp_out_byte_0,
   output logic [7:0]      rsp_out_byte_1,
   output logic [7:0]      rsp_out_byte_2,
   output logic [7:0]      rsp_out_byte_3,
   output logic            rsp_error,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data
);

   logic       start_graphics_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_som_ff;
   hist_type   hist_ff;
   hist_type   hist_in;
   result_type dec_result;
   logic       out_valid_ff;
   result_type out_ff;
   logic       advance;

   // stage moves forward when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   vtx_decode u_decode (
      .vt_byte          (in_byte_ff),
      .start_of_message (in_som_ff),
      .start_graphics   (start_graphics_ff),
      .hist             (hist_ff),
      .result           (dec_result),
      .hist_next        (hist_in)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_graphics_ff <= 1'b0;
      end else if (csr_write_enable) begin
         start_graphics_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_vt_byte;
         in_som_ff  <= req_start_of_message;
      end
   end

   // history and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            hist_ff <= hist_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_count  = out_ff.out_count;
   assign rsp_out_byte_0 = out_ff.out_bytes[0];
   assign rsp_out_byte_1 = out_ff.out_bytes[1];
   assign rsp_out_byte_2 = out_ff.out_bytes[2];
   assign rsp_out_byte_3 = out_ff.out_bytes[3];
   assign rsp_error      = out_ff.error;

endmodule

`default_nettype wire

// ===== rtl/vtx_checker.sv =====
// Port-level checks for the Videotex to UTF-8 transcoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module vtx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_out_count,
   input wire logic [7:0] rsp_out_byte_0,
   input wire logic [7:0] rsp_out_byte_3,
   input wire logic       rsp_error
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_count)
         && $stable(rsp_out_byte_0) && $stable(rsp_error))
      else $error("stalled result changed");

   // an error byte emits nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_count == 3'd0)
      else $error("error result carries bytes");

   // count never exceeds four, and the last byte is zero unless all four are used
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_count <= 3'd4 && (rsp_out_count == 3'd4 || rsp_out_byte_3 == 8'h00))
      else $error("bad result count or stray byte");

   // a result rises only after an input transfer has passed the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching input transfer");

endmodule

bind videotex_to_utf8_transcoder vtx_checker u_vtx_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_count  (rsp_out_count),
   .rsp_out_byte_0 (rsp_out_byte_0),
   .rsp_out_byte_3 (rsp_out_byte_3),
   .rsp_error      (rsp_error)
);

`default_nettype wire
